// ===== src/assert_macros.svh =====
// Assertion macros for the RTL. Every macro samples on the rising edge of
// clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/lrupr_pkg.sv =====
package lrupr_pkg;

   // Default sizes of the frame table and of a stored page number.
   localparam int FRAMES_DEF    = 16;
   localparam int PAGE_BITS_DEF = 16;

   // Fixed widths of the request and response fields.
   localparam int PAGE_PORT_W = 16;
   localparam int SLOT_PORT_W = 4;
   localparam int FAULT_W     = 32;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CFG_W      = 5;
   localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = CFG_W'(16);

   // Register index, taken from the word address.
   localparam logic REG_FRAMES_IN_USE = 1'b0;

endpackage

// ===== src/lru_page_replacement.sv =====
// LRU page replacement engine.
// A request carries one page number on req_page_number (req_valid / req_ready).
// The block keeps the resident pages in least-recently-used order and answers
// with one response per request on the rsp_ channel: the hit flag, the frame
// slot now holding the page, the evicted page if any, and the saturating fault
// total. The number of usable frames is set through the csr_ register port at
// byte address 0; writes are expected only while the block is idle.
// A request passes through a walk of the recency store, a tail step and a final
// step. A hit ends the walk at the page; a miss walks every resident page and
// also waits for the free-frame scan, which stops at the lowest free frame or at
// the last frame. From the final step the block returns to idle before the next
// request is taken. The recency store is walked one entry per cycle through its
// single read port with one page comparator, and the free-frame scan runs beside
// it. req_ready is high only between requests. The response sits in an output
// register, so a new request is accepted while the previous response still
// waits. If the receiver stalls, the block holds its next response in its last
// step until the register frees up.
// Reset empties all frames, clears the fault total and sets the frame limit to
// 16. The recency store needs no clearing pass: only live entries are read.
module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PAGE_PORT_W-1:0] req_page_number,
   // Response channel.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic [SLOT_PORT_W-1:0] rsp_frame_slot,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_PORT_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]     rsp_fault_count,
   // Register port.
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

`include "assert_macros.svh"

   localparam int PW = PAGE_BITS;
   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);
   localparam int EW = PW + IW;

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_TAIL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // Register file.
   logic [CFG_W-1:0] frames_ff, frames_in;
   logic             csr_wr;

   // Sequencer and walk state.
   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] page_ff, page_in;
   logic [EW-1:0] carry_ff, carry_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          walk_done_ff, walk_done_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_slot_ff, hit_slot_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic          scan_done_ff, scan_done_in;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_slot_ff, free_slot_in;

   // Architectural state.
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [FRAMES-1:0] used_ff, used_in;
   logic [FAULT_W-1:0] fault_ff, fault_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [SLOT_PORT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                   rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_PORT_W-1:0] rsp_ev_page_ff, rsp_ev_page_in;
   logic [FAULT_W-1:0]     rsp_fault_ff, rsp_fault_in;

   // Recency store ports.
   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   // Derived values.
   logic [CW-1:0]  limit;
   logic           evict;
   logic [PW-1:0]  ev_page;
   logic [IW-1:0]  ev_slot;
   logic [IW-1:0]  new_slot;
   logic           rsp_free;
   logic [FAULT_W-1:0] fault_next;

   lrupr_order_ram #(
      .DEPTH (FRAMES),
      .WIDTH (EW),
      .AW    (IW)
   ) u_order (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Register port. Only the frame limit exists; every access completes at once.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      frames_in = frames_ff;
      if (csr_wr && (csr_paddr[2] == REG_FRAMES_IN_USE)) begin
         frames_in = csr_pwdata[CFG_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_FRAMES_IN_USE) ? CSR_DATA_W'(frames_ff)
                                                           : '0;

   // A limit of zero behaves as one frame; anything above FRAMES is clipped.
   always_comb begin
      if (frames_ff == '0) begin
         limit = CW'(1);
      end else if (32'(frames_ff) > 32'(FRAMES)) begin
         limit = CW'(FRAMES);
      end else begin
         limit = CW'(frames_ff);
      end
   end

   // On a miss the least-recent page goes when the table is at or over the
   // limit. After the walk, carry holds that last entry.
   assign evict   = (cnt_ff >= limit);
   assign ev_page = carry_ff[EW-1:IW];
   assign ev_slot = carry_ff[IW-1:0];

   // The new page takes the lowest free frame, which may be the one just freed.
   always_comb begin
      if (hit_ff) begin
         new_slot = hit_slot_ff;
      end else if (evict) begin
         new_slot = (free_found_ff && (free_slot_ff < ev_slot)) ? free_slot_ff : ev_slot;
      end else begin
         new_slot = free_slot_ff;
      end
   end

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign fault_next = (hit_ff || (fault_ff == '1)) ? fault_ff : fault_ff + FAULT_W'(1);

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      carry_in      = carry_ff;
      idx_in        = idx_ff;
      walk_done_in  = walk_done_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      scan_in       = scan_ff;
      scan_done_in  = scan_done_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      cnt_in        = cnt_ff;
      used_in       = used_ff;
      fault_in      = fault_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_fault_in    = rsp_fault_ff;

      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = carry_ff;
      rd_en   = 1'b0;
      rd_addr = idx_ff + IW'(1);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               page_in       = PW'(req_page_number);
               carry_in      = {PW'(req_page_number), IW'(0)};
               idx_in        = '0;
               walk_done_in  = (cnt_ff == '0);
               hit_in        = 1'b0;
               scan_in       = '0;
               scan_done_in  = 1'b0;
               free_found_in = 1'b0;
               rd_en         = 1'b1;
               rd_addr       = '0;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            // Each step writes the carried entry one place down and carries the
            // entry it displaced; the walk stops at the page or at the end.
            if (!walk_done_ff) begin
               wr_en    = 1'b1;
               carry_in = rd_data;
               if (rd_data[EW-1:IW] == page_ff) begin
                  hit_in       = 1'b1;
                  hit_slot_in  = rd_data[IW-1:0];
                  walk_done_in = 1'b1;
               end else if ((CW'(idx_ff) + CW'(1)) == cnt_ff) begin
                  walk_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + IW'(1);
                  rd_en  = 1'b1;
               end
            end
            // The free-frame search runs beside the walk, one frame per cycle.
            if (!scan_done_ff) begin
               if (!used_ff[scan_ff]) begin
                  free_found_in = 1'b1;
                  free_slot_in  = scan_ff;
                  scan_done_in  = 1'b1;
               end else if (scan_ff == IW'(FRAMES - 1)) begin
                  scan_done_in = 1'b1;
               end else begin
                  scan_in = scan_ff + IW'(1);
               end
            end
            if (walk_done_ff && (scan_done_ff || hit_ff)) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            // A miss that keeps every page pushes the last one into a new place.
            if (!hit_ff && !evict) begin
               wr_en   = 1'b1;
               wr_addr = IW'(cnt_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {page_ff, new_slot};
            if (rsp_free) begin
               if (!hit_ff) begin
                  if (evict) begin
                     used_in[ev_slot] = 1'b0;
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                  end
                  used_in[new_slot] = 1'b1;
               end
               fault_in        = fault_next;
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit_ff;
               rsp_slot_in     = SLOT_PORT_W'(new_slot);
               rsp_ev_valid_in = !hit_ff && evict;
               rsp_ev_page_in  = (!hit_ff && evict) ? PAGE_PORT_W'(ev_page) : '0;
               rsp_fault_in    = fault_next;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= CFG_FRAMES_RESET;
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         used_ff      <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frames_ff    <= frames_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      carry_ff        <= carry_in;
      idx_ff          <= idx_in;
      walk_done_ff    <= walk_done_in;
      hit_ff          <= hit_in;
      hit_slot_ff     <= hit_slot_in;
      scan_ff         <= scan_in;
      scan_done_ff    <= scan_done_in;
      free_found_ff   <= free_found_in;
      free_slot_ff    <= free_slot_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_fault_ff    <= rsp_fault_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_slot    = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_fault_ff;

   // Between requests, exactly one frame is marked used per resident page.
   `ASSERT_IMPL(a_used_matches_count, state_ff == S_IDLE,
                32'($countones(used_ff)) == 32'(cnt_ff))
   // Once a request is taken, no second one is taken in the next cycle.
   `ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // A hit never moves the fault total.
   `ASSERT_NEXT(a_hit_keeps_faults, state_ff == S_DONE && rsp_free && hit_ff,
                $stable(fault_ff))

endmodule

// ===== src/lrupr_order_ram.sv =====
module lrupr_order_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 20,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   // Recency store: one write port and one registered read port.
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the LRU page replacement engine.
//
// Page references are queued by the stimulus process and handed to the request
// channel by a clocked driver. When a request is accepted, the driver runs the
// testbench's own LRU model on it and appends the predicted response to a FIFO
// of awaited lookups. A clocked monitor pops that FIFO for every accepted
// response and compares it field by field.
module tb;
   import lrupr_pkg::*;

   localparam int NUM_FRAMES     = FRAMES_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_SHOWN      = 10;
   localparam int POOL_MAX       = 32;

   // Byte address of the frame limit register, and of the unused word after it.
   localparam logic [CSR_ADDR_W-1:0] FRAMES_ADDR = CSR_ADDR_W'(REG_FRAMES_IN_USE) << 2;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR  = FRAMES_ADDR + CSR_ADDR_W'(4);

   // One predicted response of the engine.
   typedef struct packed {
      logic                   hit;
      logic [SLOT_PORT_W-1:0] slot;
      logic                   evicted;
      logic [PAGE_PORT_W-1:0] evicted_page;
      logic [FAULT_W-1:0]     faults;
   } lookup_result_type;

   // Every input of the engine has a known value from time zero.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PAGE_PORT_W-1:0] req_page_number = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_hit;
   logic [SLOT_PORT_W-1:0] rsp_frame_slot;
   logic                   rsp_evicted_valid;
   logic [PAGE_PORT_W-1:0] rsp_evicted_page;
   logic [FAULT_W-1:0]     rsp_fault_count;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Page references waiting for the driver, and predicted responses waiting
   // for the monitor.
   logic [PAGE_PORT_W-1:0] page_refs_q [$];
   lookup_result_type      awaited_lookups [$];
   int                     refs_queued = 0;
   int                     refs_accepted = 0;
   int                     responses_seen = 0;
   int                     failures = 0;
   int                     idle_cycles = 0;

   // Chance in percent that the sender idles or the receiver stalls in a cycle.
   int                     send_idle_pct = 0;
   int                     recv_stall_pct = 0;

   // Shadow state of the engine. The recency list keeps the most recent page at
   // index zero; only its first resident_pages entries are meaningful.
   logic [PAGE_PORT_W-1:0] lru_order [NUM_FRAMES];
   int                     resident_pages = 0;
   logic [PAGE_PORT_W-1:0] slot_page [NUM_FRAMES];
   logic                   slot_busy [NUM_FRAMES] = '{default: 1'b0};
   logic [FAULT_W-1:0]     fault_tally = '0;
   logic [CFG_W-1:0]       frame_limit_cfg = CFG_FRAMES_RESET;

   // A limit of zero still allows one frame, and anything beyond the table
   // size is clipped to it.
   function automatic int usable_frames(input logic [CFG_W-1:0] cfg);
      if (cfg == 0) return 1;
      if (cfg > NUM_FRAMES) return NUM_FRAMES;
      return int'(cfg);
   endfunction

   // Lowest busy slot holding the page; slot zero when none does.
   function automatic logic [SLOT_PORT_W-1:0] slot_holding(input logic [PAGE_PORT_W-1:0] page);
      for (int s = 0; s < NUM_FRAMES; s++)
         if (slot_busy[s] && slot_page[s] == page) return SLOT_PORT_W'(s);
      return '0;
   endfunction

   // Applies one page reference to the shadow state and returns the response
   // the engine must give for it.
   function automatic lookup_result_type replace_page(input logic [PAGE_PORT_W-1:0] page);
      lookup_result_type r;
      int                pos;
      r = '0;
      pos = -1;
      for (int i = 0; i < resident_pages; i++)
         if (pos < 0 && lru_order[i] == page) pos = i;

      if (pos >= 0) begin
         // A hit only reorders the list; it never evicts, even above the limit.
         for (int i = pos; i > 0; i--) lru_order[i] = lru_order[i - 1];
         lru_order[0] = page;
         r.hit  = 1'b1;
         r.slot = slot_holding(page);
      end else begin
         if (fault_tally != '1) fault_tally++;
         // At or above the limit a miss frees exactly one frame, the least
         // recent one, so resident pages never drop to a lowered limit.
         if (resident_pages >= usable_frames(frame_limit_cfg) && resident_pages > 0) begin
            r.evicted      = 1'b1;
            r.evicted_page = lru_order[resident_pages - 1];
            resident_pages--;
            slot_busy[slot_holding(r.evicted_page)] = 1'b0;
         end
         for (int i = resident_pages; i > 0; i--) lru_order[i] = lru_order[i - 1];
         lru_order[0] = page;
         resident_pages++;
         // The new page takes the lowest free slot.
         for (int s = NUM_FRAMES - 1; s >= 0; s--)
            if (!slot_busy[s]) r.slot = SLOT_PORT_W'(s);
         slot_busy[r.slot] = 1'b1;
         slot_page[r.slot] = page;
      end
      r.faults = fault_tally;
      return r;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_SHOWN) $display("%t ERROR: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         note_failure($sformatf("response %0d field %s: expected 0x%0h, got 0x%0h",
                                responses_seen, name, want, got));
   endtask

   // The driver offers the next queued page whenever the channel is free and
   // the sender is not idling this cycle. The prediction is made at the edge
   // where the request is accepted, so it sees the configuration in force then.
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_lookups.push_back(replace_page(req_page_number));
            refs_accepted++;
         end
         // Valid is only touched once the current request has gone, so it
         // never drops while a request is pending.
         if (!req_valid || req_ready) begin
            if (page_refs_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid       <= 1'b1;
               req_page_number <= page_refs_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The monitor checks each accepted response against the oldest prediction
   // and draws a fresh ready value every cycle.
   always @(posedge clock) begin : response_monitor
      lookup_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_lookups.size() == 0) begin
               note_failure($sformatf("response %0d arrived with no request outstanding",
                                      responses_seen));
            end else begin
               want = awaited_lookups.pop_front();
               check_field("hit", want.hit, rsp_hit);
               check_field("frame_slot", want.slot, rsp_frame_slot);
               check_field("evicted_valid", want.evicted, rsp_evicted_valid);
               check_field("evicted_page", want.evicted_page, rsp_evicted_page);
               check_field("fault_count", want.faults, rsp_fault_count);
            end
            responses_seen++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // The watchdog ends the run if neither channel moves for too long.
   always @(posedge clock) begin : progress_watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a handshake.", idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic queue_page(input logic [PAGE_PORT_W-1:0] page);
      page_refs_q.push_back(page);
      refs_queued++;
   endtask

   // Holds off until every queued page has been accepted and answered. Every
   // request yields a response, so the engine is idle once this returns.
   task automatic settle();
      while (refs_accepted != refs_queued || awaited_lookups.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write with a setup and an access cycle. The shadow limit follows
   // only writes that decode to the frame limit register.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((addr >> 2) == CSR_ADDR_W'(REG_FRAMES_IN_USE)) frame_limit_cfg = data[CFG_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // One random phase: set the limit (with junk in the unused upper bits),
   // then draw references mostly from a working set sized near the limit so
   // that hits, misses and evictions all occur. A sweep through the set
   // produces the classic LRU thrashing pattern. Halfway through, the sender
   // holds off until every response is back.
   task automatic run_phase(input logic [CFG_W-1:0] limit_cfg, input int idle_pct,
                            input int stall_pct, input int n_refs);
      logic [PAGE_PORT_W-1:0] pool [POOL_MAX];
      int                     pool_size;
      int                     sweep;
      int                     pick;
      settle();
      write_csr(FRAMES_ADDR, ($urandom() << CFG_W) | CSR_DATA_W'(limit_cfg));
      if ($urandom_range(1) == 1) write_csr(SPARE_ADDR, $urandom());
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      pool_size = usable_frames(limit_cfg) + $urandom_range(0, 8);
      for (int i = 0; i < pool_size; i++) pool[i] = PAGE_PORT_W'($urandom());
      sweep = 0;
      for (int n = 0; n < n_refs; n++) begin
         if (n == n_refs / 2) settle();
         pick = $urandom_range(99);
         if (pick < 65) begin
            queue_page(pool[$urandom_range(pool_size - 1)]);
         end else if (pick < 85) begin
            queue_page(pool[sweep]);
            sweep = (sweep + 1) % pool_size;
         end else begin
            queue_page(PAGE_PORT_W'($urandom()));
         end
      end
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] limits [12];
      limits = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd17, 5'd8, 5'd2, 5'd16, 5'd12, 5'd3, 5'd16};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset limit of sixteen frames: both extreme page
      // numbers, hits that reorder the list, and single-bit pages.
      queue_page(16'h0000);
      queue_page(16'hFFFF);
      queue_page(16'h0000);
      queue_page(16'h8000);
      queue_page(16'h0001);
      queue_page(16'hFFFF);

      // Limit lowered to three with four pages resident: each miss evicts one
      // page but the count does not shrink; page 0000 is evicted and misses again.
      settle();
      write_csr(FRAMES_ADDR, 32'd3);
      queue_page(16'h1111);
      queue_page(16'h0000);
      queue_page(16'h2222);

      // A limit of zero behaves like one frame.
      settle();
      write_csr(FRAMES_ADDR, 32'd0);
      queue_page(16'h3333);
      queue_page(16'h3333);

      // A write to the unused word is ignored. Then a limit above the table
      // size, with every upper data bit set, acts as sixteen; the frames fill
      // up to full capacity and none of these misses evicts.
      settle();
      write_csr(SPARE_ADDR, 32'd16);
      write_csr(FRAMES_ADDR, 32'hFFFF_FFFF);
      for (int i = 0; i < 12; i++) queue_page(PAGE_PORT_W'(16'h4000 + i));

      // Random part. Idling modes rotate: none, sender idle, receiver stalling,
      // both lightly.
      foreach (limits[p]) begin
         case (p % 4)
            0: run_phase(limits[p], 0, 0, 140);
            1: run_phase(limits[p], 76, 0, 140);
            2: run_phase(limits[p], 0, 76, 140);
            default: run_phase(limits[p], 25, 25, 140);
         endcase
      end

      settle();
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
